// File: design/lztsd_pkg.sv
// Shared constants for the LZ tag stream decompressor.
`timescale 1ns / 1ps
package lztsd_pkg;

  localparam int unsigned HistoryDepthDef = 65536;

  localparam logic [5:0] LongLitCode  = 6'd60;
  localparam logic [5:0] LongLitBias  = 6'd59;
  localparam logic [7:0] VarintMore   = 8'(1 << 7);
  localparam logic [6:0] ShortCopyBase = 7'(1 << 2);
  localparam logic [2:0] ShortCopyMask = 3'((1 << 3) - 1);

  localparam logic [2:0] PhPreamble = 3'd0;
  localparam logic [2:0] PhTag      = 3'd1;
  localparam logic [2:0] PhLitLen   = 3'd2;
  localparam logic [2:0] PhLitData  = 3'd3;
  localparam logic [2:0] PhOff1     = 3'd4;
  localparam logic [2:0] PhOff2Lo   = 3'd5;
  localparam logic [2:0] PhOff2Hi   = 3'd6;

endpackage

// File: design/lz_tag_stream_decompressor.sv
// Byte-serial decoder for a tagged LZ compressed stream with history memory.
//
// Input channel: one compressed byte per transfer (in_byte_i), final_byte_i
// marks the last byte of a stream. Output channel: one decompressed byte per
// transfer with run_last_o on the last result of an input byte, bad_offset_o
// on the single error result of an invalid copy, stream_done_o on all
// results of a final byte.
// Preamble, tag, length and low offset bytes give no result; the byte that
// completes an offset gives the error result if the offset is invalid, else
// starts a copy. A literal byte gives one result in the output register.
// A copy of up to 64 bytes handles each byte as a read of the history memory
// into a register, then a write back and output. Input is held off during
// a copy. Any input byte is taken only once the output register is free or
// draining in the same cycle; a stalled receiver simply holds the output
// register, which stops both the input and the copy sequencer.
// Reset clears the parser and empties the history; no clearing pass is
// needed because copies only read entries that were written. A final byte
// returns the parser to the preamble and empties the history after its work.
`timescale 1ns / 1ps
module lz_tag_stream_decompressor #(
  parameter int unsigned HISTORY_DEPTH = lztsd_pkg::HistoryDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       bad_offset_o,
  output logic       stream_done_o
);

  localparam int unsigned AW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned BW_W = $clog2(HISTORY_DEPTH + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StWrite = 2'd2;

  logic [1:0]      ctrl_q, ctrl_d;
  logic [2:0]      phase_q, phase_d;
  logic [32:0]     lit_left_q, lit_left_d;
  logic [2:0]      extra_q, extra_d;
  logic [31:0]     len_acc_q, len_acc_d;
  logic [1:0]      len_shift_q, len_shift_d;
  logic [6:0]      copy_len_q, copy_len_d;
  logic [15:0]     off_acc_q, off_acc_d;
  logic [AW-1:0]   wp_q, wp_d;
  logic [BW_W-1:0] bw_q, bw_d;
  logic [6:0]      cnt_q, cnt_d;
  logic [15:0]     copy_off_q, copy_off_d;
  logic            fin_q, fin_d;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            run_last_q, run_last_d;
  logic            bad_q, bad_d;
  logic            done_q, done_d;
  logic            out_load;

  logic [7:0]      mem [HISTORY_DEPTH];
  logic [7:0]      rd_data_q;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      wr_data;

  logic            out_free, in_acc;
  logic [5:0]      code;
  logic [15:0]     off_new;
  logic            off_bad, push;
  logic [31:0]     acc_new;
  logic [2:0]      extra_new;
  logic [BW_W-1:0] wp_inc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (ctrl_q == StIdle) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign code       = in_byte_i[7:2];

  assign acc_new   = len_acc_q | (32'(in_byte_i) << {len_shift_q, 3'b000});
  assign extra_new = (extra_q != 3'd0) ? extra_q - 3'd1 : 3'd0;

  // shared address unit: wrap increment and backward source address
  assign wp_inc = BW_W'(wp_q) + BW_W'(1);
  always_comb begin
    if (32'(wp_q) >= 32'(copy_off_q)) begin
      rd_addr = AW'(32'(wp_q) - 32'(copy_off_q));
    end else begin
      rd_addr = AW'(32'(wp_q) + 32'(HISTORY_DEPTH) - 32'(copy_off_q));
    end
  end

  always_comb begin
    off_new = off_acc_q;
    case (phase_q)
      lztsd_pkg::PhOff1:   off_new = off_acc_q + 16'(in_byte_i);
      lztsd_pkg::PhOff2Hi: off_new = off_acc_q | {in_byte_i, 8'h00};
      default:             off_new = off_acc_q;
    endcase
  end
  assign off_bad = (off_new == 16'd0) || (32'(off_new) > 32'(bw_q));

  always_comb begin
    ctrl_d      = ctrl_q;
    phase_d     = phase_q;
    lit_left_d  = lit_left_q;
    extra_d     = extra_q;
    len_acc_d   = len_acc_q;
    len_shift_d = len_shift_q;
    copy_len_d  = copy_len_q;
    off_acc_d   = off_acc_q;
    wp_d        = wp_q;
    bw_d        = bw_q;
    cnt_d       = cnt_q;
    copy_off_d  = copy_off_q;
    fin_d       = fin_q;
    out_load    = 1'b0;
    out_byte_d  = out_byte_q;
    run_last_d  = run_last_q;
    bad_d       = bad_q;
    done_d      = done_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = in_byte_i;
    push        = 1'b0;

    case (ctrl_q)
      StIdle: begin
        if (in_acc) begin
          case (phase_q)
            lztsd_pkg::PhPreamble: begin
              if ((in_byte_i & lztsd_pkg::VarintMore) == 8'h00) begin
                phase_d = lztsd_pkg::PhTag;
              end
            end
            lztsd_pkg::PhTag: begin
              if (in_byte_i[1:0] == 2'b00) begin
                if (code >= lztsd_pkg::LongLitCode) begin
                  extra_d     = 3'(code - lztsd_pkg::LongLitBias);
                  len_acc_d   = 32'd0;
                  len_shift_d = 2'd0;
                  phase_d     = lztsd_pkg::PhLitLen;
                end else begin
                  lit_left_d = 33'(code) + 33'd1;
                  phase_d    = lztsd_pkg::PhLitData;
                end
              end else if (in_byte_i[1]) begin
                copy_len_d = 7'(code) + 7'd1;
                off_acc_d  = 16'd0;
                phase_d    = lztsd_pkg::PhOff2Lo;
              end else begin
                copy_len_d = 7'(code[2:0] & lztsd_pkg::ShortCopyMask)
                             + lztsd_pkg::ShortCopyBase;
                off_acc_d  = {5'd0, in_byte_i[7:5], 8'h00};
                phase_d    = lztsd_pkg::PhOff1;
              end
            end
            lztsd_pkg::PhLitLen: begin
              len_acc_d   = acc_new;
              len_shift_d = len_shift_q + 2'd1;
              extra_d     = extra_new;
              if (extra_new == 3'd0) begin
                lit_left_d = 33'(acc_new) + 33'd1;
                phase_d    = lztsd_pkg::PhLitData;
              end
            end
            lztsd_pkg::PhLitData: begin
              wr_en      = 1'b1;
              push       = 1'b1;
              out_load   = 1'b1;
              out_byte_d = in_byte_i;
              run_last_d = 1'b1;
              bad_d      = 1'b0;
              done_d     = final_byte_i;
              if (lit_left_q != 33'd0) begin
                lit_left_d = lit_left_q - 33'd1;
              end
              if (lit_left_q <= 33'd1) begin
                phase_d = lztsd_pkg::PhTag;
              end
            end
            lztsd_pkg::PhOff1, lztsd_pkg::PhOff2Hi: begin
              off_acc_d = off_new;
              phase_d   = lztsd_pkg::PhTag;
              if (off_bad) begin
                out_load   = 1'b1;
                out_byte_d = 8'h00;
                run_last_d = 1'b1;
                bad_d      = 1'b1;
                done_d     = final_byte_i;
              end else begin
                ctrl_d     = StRead;
                cnt_d      = copy_len_q;
                copy_off_d = off_new;
                fin_d      = final_byte_i;
              end
            end
            lztsd_pkg::PhOff2Lo: begin
              off_acc_d = {8'h00, in_byte_i};
              phase_d   = lztsd_pkg::PhOff2Hi;
            end
            default: phase_d = lztsd_pkg::PhTag;
          endcase

          if (final_byte_i) begin
            phase_d     = lztsd_pkg::PhPreamble;
            lit_left_d  = 33'd0;
            extra_d     = 3'd0;
            len_acc_d   = 32'd0;
            len_shift_d = 2'd0;
            copy_len_d  = 7'd0;
            off_acc_d   = 16'd0;
          end
        end
      end
      StRead: begin
        rd_en  = 1'b1;
        ctrl_d = StWrite;
      end
      StWrite: begin
        if (out_free) begin
          wr_en      = 1'b1;
          wr_data    = rd_data_q;
          push       = 1'b1;
          out_load   = 1'b1;
          out_byte_d = rd_data_q;
          run_last_d = (cnt_q == 7'd1);
          bad_d      = 1'b0;
          done_d     = fin_q;
          cnt_d      = cnt_q - 7'd1;
          ctrl_d     = (cnt_q == 7'd1) ? StIdle : StRead;
        end
      end
      default: ctrl_d = StIdle;
    endcase

    if (push) begin
      wp_d = (wp_inc == BW_W'(HISTORY_DEPTH)) ? '0 : AW'(wp_inc);
      if (bw_q != BW_W'(HISTORY_DEPTH)) begin
        bw_d = bw_q + BW_W'(1);
      end
    end

    // end of stream empties the history once the byte's work is done
    if ((in_acc && final_byte_i && (ctrl_d == StIdle)) ||
        ((ctrl_q == StWrite) && (ctrl_d == StIdle) && fin_q)) begin
      wp_d = '0;
      bw_d = '0;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= StIdle;
      phase_q     <= lztsd_pkg::PhPreamble;
      lit_left_q  <= '0;
      extra_q     <= '0;
      len_acc_q   <= '0;
      len_shift_q <= '0;
      copy_len_q  <= '0;
      off_acc_q   <= '0;
      wp_q        <= '0;
      bw_q        <= '0;
      cnt_q       <= '0;
      copy_off_q  <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ctrl_q      <= ctrl_d;
      phase_q     <= phase_d;
      lit_left_q  <= lit_left_d;
      extra_q     <= extra_d;
      len_acc_q   <= len_acc_d;
      len_shift_q <= len_shift_d;
      copy_len_q  <= copy_len_d;
      off_acc_q   <= off_acc_d;
      wp_q        <= wp_d;
      bw_q        <= bw_d;
      cnt_q       <= cnt_d;
      copy_off_q  <= copy_off_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    run_last_q <= run_last_d;
    bad_q      <= bad_d;
    done_q     <= done_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = run_last_q;
  assign bad_offset_o  = bad_q;
  assign stream_done_o = done_q;

endmodule
